[design/mer_pkg.sv]
package mer_pkg;

  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 9;
  localparam int PIX_BITS    = 12;

  localparam int X_BITS      = RADIUS_BITS + 1;
  localparam int Y_BITS      = RADIUS_BITS + 2;
  localparam int TX_BITS     = RADIUS_BITS + 2;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;
  localparam int SLOPE_BITS  = 3 * RADIUS_BITS + 4;
  localparam int MUL_A_BITS  = SQ_BITS;
  localparam int MUL_B_BITS  = 2 * TX_BITS;
  localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int DEC_BITS    = PROD_BITS + 2;

  localparam int IN_FIELD_BITS  = 2 * COORD_BITS + 2 * RADIUS_BITS;
  localparam int IN_TDATA_BITS  = (IN_FIELD_BITS + 7) / 8 * 8;
  localparam int OUT_TDATA_BITS = (2 * PIX_BITS + 7) / 8 * 8;

  localparam int CX_LSB = 0;
  localparam int CY_LSB = CX_LSB + COORD_BITS;
  localparam int RX_LSB = CY_LSB + COORD_BITS;
  localparam int RY_LSB = RX_LSB + RADIUS_BITS;

  localparam logic [2:0] SETUP_LAST  = 3'd3;
  localparam logic [2:0] SWITCH_LAST = 3'd5;
  localparam logic [1:0] PIX_LAST    = 2'd3;

  localparam logic ACT_START = 1'b0;

  typedef enum logic [1:0] {
    REG_IDLE = 2'd0,
    REG_ONE  = 2'd1,
    REG_TWO  = 2'd2
  } region_e;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_SU0  = 4'd2,
    OP_SU1  = 4'd3,
    OP_SU2  = 4'd4,
    OP_SU3  = 4'd5,
    OP_ADV  = 4'd6,
    OP_SW0  = 4'd7,
    OP_SW1  = 4'd8,
    OP_SW2  = 4'd9,
    OP_SW3  = 4'd10,
    OP_SW4  = 4'd11,
    OP_SW5  = 4'd12
  } op_e;

  typedef struct packed {
    op_e        op;
    region_e    region;
    logic [1:0] pix_sel;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic change;
  } sts_t;

endpackage

[design/mer_ctrl.sv]
module mer_ctrl
  import mer_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  input  logic action_i,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output logic s_ready_o,
  output logic m_valid_o,
  output logic m_last_o,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETUP  = 4'b0010,
    ST_SWITCH = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  region_e    region_q, region_d;
  logic [2:0] seq_q, seq_d;
  logic [1:0] pix_q, pix_d;
  logic       emit_done;
  logic       accept;

  assign emit_done = (state_q == ST_EMIT) && m_ready_i && (pix_q == PIX_LAST);
  assign s_ready_o = (state_q == ST_IDLE) || emit_done;
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = (state_q == ST_EMIT);
  assign m_last_o  = (pix_q == PIX_LAST);

  always_comb begin
    state_d        = state_q;
    region_d       = region_q;
    seq_d          = seq_q;
    pix_d          = pix_q;
    cmd_o.op       = OP_NONE;
    cmd_o.region   = region_q;
    cmd_o.pix_sel  = pix_q;
    case (state_q)
      ST_SETUP: begin
        case (seq_q)
          3'd0:    cmd_o.op = OP_SU0;
          3'd1:    cmd_o.op = OP_SU1;
          3'd2:    cmd_o.op = OP_SU2;
          default: cmd_o.op = OP_SU3;
        endcase
        seq_d = seq_q + 3'd1;
        if (seq_q == SETUP_LAST) begin
          state_d = ST_IDLE;
          seq_d   = '0;
        end
      end
      ST_SWITCH: begin
        case (seq_q)
          3'd0:    cmd_o.op = OP_SW0;
          3'd1:    cmd_o.op = OP_SW1;
          3'd2:    cmd_o.op = OP_SW2;
          3'd3:    cmd_o.op = OP_SW3;
          3'd4:    cmd_o.op = OP_SW4;
          default: cmd_o.op = OP_SW5;
        endcase
        seq_d = seq_q + 3'd1;
        if (seq_q == SWITCH_LAST) begin
          state_d = ST_EMIT;
          seq_d   = '0;
        end
      end
      ST_EMIT: begin
        if (m_ready_i) begin
          pix_d = pix_q + 2'd1;
          if (pix_q == PIX_LAST) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    if (accept) begin
      if (action_i == ACT_START) begin
        cmd_o.op = OP_LOAD;
        state_d  = ST_SETUP;
        seq_d    = '0;
        region_d = REG_ONE;
      end else if (region_q != REG_IDLE) begin
        cmd_o.op = OP_ADV;
        seq_d    = '0;
        pix_d    = '0;
        if (sts_i.fin) begin
          region_d = REG_IDLE;
        end else if (sts_i.change) begin
          region_d = REG_TWO;
        end
        state_d = sts_i.change ? ST_SWITCH : ST_EMIT;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      region_q <= REG_IDLE;
      seq_q    <= '0;
      pix_q    <= '0;
    end else begin
      state_q  <= state_d;
      region_q <= region_d;
      seq_q    <= seq_d;
      pix_q    <= pix_d;
    end
  end

endmodule

[design/mer_dpath.sv]
module mer_dpath
  import mer_pkg::*;
(
  input  logic                       clk_i,
  input  cmd_t                       cmd_i,
  input  logic [COORD_BITS-1:0]      center_x_i,
  input  logic [COORD_BITS-1:0]      center_y_i,
  input  logic [RADIUS_BITS-1:0]     radius_x_i,
  input  logic [RADIUS_BITS-1:0]     radius_y_i,
  output sts_t                       sts_o,
  output logic signed [PIX_BITS-1:0] pixel_x_o,
  output logic signed [PIX_BITS-1:0] pixel_y_o,
  output logic                       finished_o
);

  logic [COORD_BITS-1:0]         cx_q, cy_q;
  logic [RADIUS_BITS-1:0]        rx_q, ry_q;
  logic [SQ_BITS-1:0]            rx2_q, ry2_q;
  logic [X_BITS-1:0]             x_q, x_n, emit_x_q;
  logic signed [Y_BITS-1:0]      y_q, y_n;
  logic [X_BITS-1:0]             emit_y_q;
  logic                          fin_q;
  logic signed [SLOPE_BITS-1:0]  sa_q, sb_q, sa_n, sb_n, sa1, sb1;
  logic signed [DEC_BITS-1:0]    dec_q, dec_n;
  logic signed [DEC_BITS-1:0]    rx2w, ry2w, sa1w, sb1w, prod4w;
  logic [PROD_BITS-1:0]          prod_q, prod_d;
  logic [MUL_A_BITS-1:0]         mul_a;
  logic [MUL_B_BITS-1:0]         mul_b;
  logic [TX_BITS-1:0]            tx;
  logic [X_BITS-1:0]             ym;
  logic signed [PIX_BITS-1:0]    xw, yw, cxw, cyw;

  assign rx2w   = $signed(DEC_BITS'(rx2_q));
  assign ry2w   = $signed(DEC_BITS'(ry2_q));
  assign sa1    = sa_q + $signed(SLOPE_BITS'({ry2_q, 1'b0}));
  assign sb1    = sb_q - $signed(SLOPE_BITS'({rx2_q, 1'b0}));
  assign sa1w   = DEC_BITS'(sa1);
  assign sb1w   = DEC_BITS'(sb1);
  assign prod4w = $signed({prod_q, 2'b00});
  assign tx     = {x_q, 1'b1};
  assign ym     = (y_q == '0) ? X_BITS'(1) : X_BITS'(y_q - $signed(Y_BITS'(1)));

  always_comb begin
    x_n   = x_q;
    y_n   = y_q;
    sa_n  = sa_q;
    sb_n  = sb_q;
    dec_n = dec_q;
    if (cmd_i.region == REG_TWO) begin
      y_n  = y_q - $signed(Y_BITS'(1));
      sb_n = sb1;
      if (dec_q[DEC_BITS-1]) begin
        x_n   = x_q + X_BITS'(1);
        sa_n  = sa1;
        dec_n = dec_q + ((sa1w - sb1w + rx2w) <<< 2);
      end else begin
        dec_n = dec_q + ((rx2w - sb1w) <<< 2);
      end
    end else begin
      x_n  = x_q + X_BITS'(1);
      sa_n = sa1;
      if (dec_q[DEC_BITS-1]) begin
        dec_n = dec_q + sa1w + ry2w;
      end else begin
        y_n   = y_q - $signed(Y_BITS'(1));
        sb_n  = sb1;
        dec_n = dec_q + sa1w - sb1w + ry2w;
      end
    end
  end

  assign sts_o.fin    = y_n[Y_BITS-1];
  assign sts_o.change = (cmd_i.region == REG_ONE) && !y_n[Y_BITS-1] && (sa_n > sb_n);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SU0: begin
        mul_a = MUL_A_BITS'(rx_q);
        mul_b = MUL_B_BITS'(rx_q);
      end
      OP_SU1: begin
        mul_a = MUL_A_BITS'(ry_q);
        mul_b = MUL_B_BITS'(ry_q);
      end
      OP_SU2: begin
        mul_a = rx2_q;
        mul_b = MUL_B_BITS'(ry_q);
      end
      OP_SW0: begin
        mul_a = MUL_A_BITS'(tx);
        mul_b = MUL_B_BITS'(tx);
      end
      OP_SW1: begin
        mul_a = ry2_q;
        mul_b = prod_q[MUL_B_BITS-1:0];
      end
      OP_SW2: begin
        mul_a = MUL_A_BITS'(ym);
        mul_b = MUL_B_BITS'(ym);
      end
      OP_SW3: begin
        mul_a = rx2_q;
        mul_b = prod_q[MUL_B_BITS-1:0];
      end
      OP_SW4: begin
        mul_a = rx2_q;
        mul_b = MUL_B_BITS'(ry2_q);
      end
      default: begin
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cx_q <= center_x_i;
        cy_q <= center_y_i;
        rx_q <= radius_x_i;
        ry_q <= radius_y_i;
      end
      OP_SU0: begin
        prod_q <= prod_d;
      end
      OP_SU1: begin
        rx2_q  <= prod_q[SQ_BITS-1:0];
        prod_q <= prod_d;
      end
      OP_SU2: begin
        ry2_q  <= prod_q[SQ_BITS-1:0];
        prod_q <= prod_d;
      end
      OP_SU3: begin
        sb_q  <= $signed(SLOPE_BITS'({prod_q, 1'b0}));
        sa_q  <= '0;
        dec_q <= ry2w - $signed(DEC_BITS'(prod_q)) + $signed(DEC_BITS'(rx2_q >> 2));
        x_q   <= '0;
        y_q   <= $signed(Y_BITS'(ry_q));
      end
      OP_ADV: begin
        emit_x_q <= x_q;
        emit_y_q <= X_BITS'(y_q);
        fin_q    <= sts_o.fin;
        x_q      <= x_n;
        y_q      <= y_n;
        sa_q     <= sa_n;
        sb_q     <= sb_n;
        dec_q    <= dec_n;
      end
      OP_SW0, OP_SW1, OP_SW3: begin
        prod_q <= prod_d;
      end
      OP_SW2: begin
        dec_q  <= $signed(DEC_BITS'(prod_q));
        prod_q <= prod_d;
      end
      OP_SW4: begin
        dec_q  <= dec_q + prod4w;
        prod_q <= prod_d;
      end
      OP_SW5: begin
        dec_q <= dec_q - prod4w;
      end
      default: begin
      end
    endcase
  end

  assign xw  = $signed(PIX_BITS'(emit_x_q));
  assign yw  = $signed(PIX_BITS'(emit_y_q));
  assign cxw = $signed(PIX_BITS'(cx_q));
  assign cyw = $signed(PIX_BITS'(cy_q));

  assign pixel_x_o  = cmd_i.pix_sel[0] ? (cxw - xw) : (cxw + xw);
  assign pixel_y_o  = cmd_i.pix_sel[1] ? (cyw - yw) : (cyw + yw);
  assign finished_o = fin_q;

endmodule

[design/midpoint_ellipse_rasterizer_top.sv]
// Channel   Direction  tdata (low bit up)                        tuser / tlast
// s_axis    in         center_x, center_y, radius_x, radius_y   tuser: action
// m_axis    out        pixel_x, pixel_y                          tuser: finished,
//                                                                tlast: last_of_run
//
// A step word advances the point in the cycle it is taken and then delivers its four
// pixel words, and the next word can be taken in the cycle of the fourth pixel.
// A step word taken while no ellipse is open gives no output.
// The step that enters region two first runs the six switch steps on the shared multiplier.
// A start word loads the fields and runs the four setup steps, and gives no output.
// Output stalls hold the current pixel and the input; reset leaves the block idle.
module midpoint_ellipse_rasterizer_top
  import mer_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // center_x, center_y, radius_x, radius_y, zero fill
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  // action
  input  logic                      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // pixel_x, pixel_y
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  // finished
  output logic                      m_axis_tuser_o,
  output logic                      m_axis_tlast_o
);

  cmd_t                       cmd;
  sts_t                       sts;
  logic signed [PIX_BITS-1:0] pixel_x, pixel_y;

  mer_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .action_i  (s_axis_tuser_i),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_last_o  (m_axis_tlast_o),
    .cmd_o     (cmd)
  );

  mer_dpath u_dpath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .center_x_i (s_axis_tdata_i[CX_LSB +: COORD_BITS]),
    .center_y_i (s_axis_tdata_i[CY_LSB +: COORD_BITS]),
    .radius_x_i (s_axis_tdata_i[RX_LSB +: RADIUS_BITS]),
    .radius_y_i (s_axis_tdata_i[RY_LSB +: RADIUS_BITS]),
    .sts_o      (sts),
    .pixel_x_o  (pixel_x),
    .pixel_y_o  (pixel_y),
    .finished_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OUT_TDATA_BITS'({pixel_y, pixel_x});

endmodule

[design/mer_checker.sv]
module mer_checker
  import mer_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_tready_i,
  input logic                      m_tvalid_i,
  input logic                      m_tready_i,
  input logic [OUT_TDATA_BITS-1:0] m_tdata_i,
  input logic                      m_tuser_i,
  input logic                      m_tlast_i
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i)))
    else $error("stalled output word changed");

  // No new input is taken while a run of pixels is open.
  a_no_input_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tlast_i) |-> !s_tready_i)
    else $error("input ready in the middle of a pixel run");

  // The run continues at once after a word that is not last, with the same finish flag.
  a_run_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && m_tready_i && !m_tlast_i) |=> (m_tvalid_i && $stable(m_tuser_i)))
    else $error("finish flag changed within a run");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);

[tb/tb_top.sv]
module tb_top
  import mer_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_WORDS = 110;
  localparam int MAX_GAP = 11;

  typedef struct {
    logic [PIX_BITS-1:0] px;
    logic [PIX_BITS-1:0] py;
    logic                last;
    logic                fin;
  } pixel_t;

  class pixel_scoreboard;
    logic [COORD_BITS-1:0] ctr_col;
    logic [COORD_BITS-1:0] ctr_row;
    longint rx_sq;
    longint ry_sq;
    longint pt_x;
    longint pt_y;
    longint dec;
    longint slope_a;
    longint slope_b;
    region_e region;
    pixel_t expected_q[$];
    int errors;

    function new();
      ctr_col = '0;
      ctr_row = '0;
      rx_sq = 0;
      ry_sq = 0;
      pt_x = 0;
      pt_y = 0;
      dec = 0;
      slope_a = 0;
      slope_b = 0;
      region = REG_IDLE;
      errors = 0;
    endfunction

    function bit busy();
      return region != REG_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_pixel(longint px, longint py, logic last, logic fin);
      pixel_t p;
      p.px = px[PIX_BITS-1:0];
      p.py = py[PIX_BITS-1:0];
      p.last = last;
      p.fin = fin;
      expected_q.push_back(p);
    endfunction

    // Loads a start word, or advances the open first-quadrant point and queues the four mirrored pixels.
    function void note_word(logic act, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                            logic [RADIUS_BITS-1:0] rx, logic [RADIUS_BITS-1:0] ry);
      longint x;
      longint y;
      longint cxl;
      longint cyl;
      longint tx;
      logic fin;
      if (act == ACT_START) begin
        ctr_col = cx;
        ctr_row = cy;
        rx_sq = longint'(rx) * longint'(rx);
        ry_sq = longint'(ry) * longint'(ry);
        pt_x = 0;
        pt_y = longint'(ry);
        slope_a = 0;
        slope_b = 2 * rx_sq * pt_y;
        dec = ry_sq - rx_sq * pt_y + rx_sq / 4;
        region = REG_ONE;
        return;
      end
      if (region == REG_IDLE) return;
      x = pt_x;
      y = pt_y;
      cxl = longint'(ctr_col);
      cyl = longint'(ctr_row);
      if (region == REG_ONE) begin
        pt_x = x + 1;
        slope_a = 2 * ry_sq * pt_x;
        if (dec < 0) begin
          dec = dec + slope_a + ry_sq;
        end else begin
          pt_y = y - 1;
          slope_b = 2 * rx_sq * pt_y;
          dec = dec + slope_a - slope_b + ry_sq;
        end
      end else begin
        pt_y = y - 1;
        slope_b = 2 * rx_sq * pt_y;
        if (dec < 0) begin
          pt_x = x + 1;
          slope_a = 2 * ry_sq * pt_x;
          dec = dec + 4 * (slope_a - slope_b + rx_sq);
        end else begin
          dec = dec + 4 * (rx_sq - slope_b);
        end
      end
      fin = 1'b0;
      if (pt_y < 0) begin
        fin = 1'b1;
        region = REG_IDLE;
      end else if (region == REG_ONE && slope_a > slope_b) begin
        tx = 2 * pt_x + 1;
        region = REG_TWO;
        dec = ry_sq * tx * tx + 4 * rx_sq * (pt_y - 1) * (pt_y - 1) - 4 * rx_sq * ry_sq;
      end
      push_pixel(cxl + x, cyl + y, 1'b0, fin);
      push_pixel(cxl - x, cyl + y, 1'b0, fin);
      push_pixel(cxl + x, cyl - y, 1'b0, fin);
      push_pixel(cxl - x, cyl - y, 1'b1, fin);
    endfunction

    function void check_pixel(logic [PIX_BITS-1:0] px, logic [PIX_BITS-1:0] py,
                              logic last, logic fin);
      pixel_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected pixel word x=%0h y=%0h", px, py);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (px !== e.px) begin
        $error("pixel_x: expected %0h, got %0h", e.px, px);
        errors++;
      end
      if (py !== e.py) begin
        $error("pixel_y: expected %0h, got %0h", e.py, py);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0b, got %0b", e.last, last);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("finished: expected %0b, got %0b", e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid_i;
  logic                      s_axis_tready_o;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i;
  logic                      s_axis_tuser_i;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o;
  logic                      m_axis_tuser_o;
  logic                      m_axis_tlast_o;

  pixel_scoreboard sb;
  int  cycles;
  int  stall_left;
  bit  tx_burst;
  bit  rx_burst;
  int  random_words;

  midpoint_ellipse_rasterizer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // The pixel side checks each accepted word and draws the stall before the next one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_pixel(m_axis_tdata_o[PIX_BITS-1:0], m_axis_tdata_o[2*PIX_BITS-1:PIX_BITS],
                     m_axis_tlast_o, m_axis_tuser_o);
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall_left = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic act, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                           logic [RADIUS_BITS-1:0] rx, logic [RADIUS_BITS-1:0] ry);
    int gap;
    logic [IN_TDATA_BITS-1:0] word;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    word = '0;
    word[CX_LSB +: COORD_BITS] = cx;
    word[CY_LSB +: COORD_BITS] = cy;
    word[RX_LSB +: RADIUS_BITS] = rx;
    word[RY_LSB +: RADIUS_BITS] = ry;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= act;
    s_axis_tdata_i <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_word(act, cx, cy, rx, ry);
    @(negedge clk_i);
  endtask

  task automatic send_step();
    send_word(!ACT_START, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
              RADIUS_BITS'($urandom()), RADIUS_BITS'($urandom()));
    random_words++;
  endtask

  task automatic send_start(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                            logic [RADIUS_BITS-1:0] rx, logic [RADIUS_BITS-1:0] ry);
    send_word(ACT_START, cx, cy, rx, ry);
    random_words++;
  endtask

  task automatic step_to_end();
    while (sb.busy()) send_step();
  endtask

  initial begin
    bit paused;
    int steps;
    logic [RADIUS_BITS-1:0] rx;
    logic [RADIUS_BITS-1:0] ry;
    sb = new();
    cycles = 0;
    stall_left = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    paused = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    m_axis_tready_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_step();
    send_start('0, '0, '0, '0);
    step_to_end();
    send_step();
    send_start('1, '1, '1, '1);
    repeat (3) send_step();
    send_start('0, '1, '1, '0);
    step_to_end();
    send_start('1, '0, '0, '1);
    repeat (3) send_step();
    send_start(10'd512, 10'd512, 9'd5, 9'd3);
    step_to_end();
    send_start(10'd3, 10'd1020, 9'd2, 9'd6);
    step_to_end();

    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if (!paused && random_words >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        s_axis_tvalid_i <= 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
        repeat (DRAIN_CYCLES) @(negedge clk_i);
      end
      if ($urandom_range(0, 19) == 0) begin
        send_word(!ACT_START, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                  RADIUS_BITS'($urandom()), RADIUS_BITS'($urandom()));
      end else if ($urandom_range(0, 7) == 0) begin
        rx = RADIUS_BITS'($urandom_range(0, (1 << RADIUS_BITS) - 1));
        ry = RADIUS_BITS'($urandom_range(0, (1 << RADIUS_BITS) - 1));
        send_start(COORD_BITS'($urandom()), COORD_BITS'($urandom()), rx, ry);
        steps = $urandom_range(0, 6);
        repeat (steps) send_step();
      end else begin
        rx = RADIUS_BITS'($urandom_range(0, 12));
        ry = RADIUS_BITS'($urandom_range(0, 12));
        send_start(COORD_BITS'($urandom()), COORD_BITS'($urandom()), rx, ry);
        if ($urandom_range(0, 9) < 7) begin
          step_to_end();
        end else begin
          steps = $urandom_range(0, 6);
          repeat (steps) send_step();
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
